// ----- rtl/core/brf_pkg.sv -----
// Package for the byte ring FIFO with statistics.
// Holds field widths, operation and status codes, and the result word layout.
// No dependencies.
package brf_pkg;

	localparam int unsigned DEPTH_DEF = 1024;

	localparam int unsigned W_KIND   = 3;
	localparam int unsigned W_BYTE   = 8;
	localparam int unsigned W_LEN    = 11;
	localparam int unsigned W_STATUS = 2;
	localparam int unsigned W_TALLY  = 32;

	// Capacity register value after reset
	localparam logic [W_LEN-1:0] CAP_RESET = 11'd1024;

	// Input word: data_byte, count; packed to whole bytes
	localparam int unsigned W_IN_DATA  = 24;
	// Result word: all result fields; packed to whole bytes
	localparam int unsigned W_OUT_DATA = 168;

	typedef enum logic [W_KIND-1:0] {
		KIND_PUSH       = 3'd0,
		KIND_POP        = 3'd1,
		KIND_SKIP_READ  = 3'd2,
		KIND_SKIP_WRITE = 3'd3,
		KIND_CLEAR      = 3'd4
	} kind_t;

	typedef enum logic [W_STATUS-1:0] {
		ST_OK      = 2'd0,
		ST_REFUSED = 2'd1,
		ST_SKIP    = 2'd2
	} status_t;

	// Declared last field first, so read_data lands in the lowest bits
	typedef struct packed {
		logic [W_LEN-1:0]   contiguous_write;
		logic [W_LEN-1:0]   contiguous_read;
		logic [W_TALLY-1:0] bytes_consumed;
		logic [W_TALLY-1:0] empty_events;
		logic [W_TALLY-1:0] full_events;
		logic [W_LEN-1:0]   peak_used;
		logic [W_LEN-1:0]   free_bytes;
		logic [W_LEN-1:0]   used_bytes;
		status_t            status;
		logic [W_BYTE-1:0]  read_data;
	} result_t;

endpackage

// ----- rtl/core/brf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the byte store of the ring FIFO. No dependencies.
module brf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/byte_ring_fifo_with_stats.sv -----
// Top level of the byte ring FIFO with statistics.
// Depends on brf_pkg (codes, widths, result layout) and brf_ram (byte store).
//
// Usage:
//   Input words arrive on s_axis: tuser carries the operation (push, pop,
//   skip read, skip write, clear all), tdata the byte to push and the skip
//   count. Every input word yields exactly one result word on m_axis that
//   reports the popped byte, a status code and the FIFO state after the
//   operation: occupancy, free space, high-water mark, full/empty event
//   tallies, bytes consumed and the contiguous read and write lengths.
//   The capacity register (cfg_we/cfg_wdata) sets how many store slots are
//   in use; 0 acts as 1 and values above DEPTH act as DEPTH. Writing it
//   also empties the FIFO while keeping the statistics. Write it only while
//   no word is in flight.
//   Each word passes the execute stage, then the output register. Throughput
//   is one word per cycle while m_axis does not stall: the store read for a
//   pop is issued at the accept edge, with the read index of the word ahead
//   forwarded into the read address and a push to the same slot bypassed.
//   When m_axis stalls, the finished result holds in the output register,
//   one more word is taken into the execute stage and then s_axis_tready
//   drops until the result is taken.
//   Reset: capacity 1024 (clamped to DEPTH), indices, occupancy and all
//   statistics zero; the store itself is not cleared.
module byte_ring_fifo_with_stats #(
	parameter int unsigned DEPTH = brf_pkg::DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// capacity register
	input  logic                           cfg_we,
	input  logic [brf_pkg::W_LEN-1:0]      cfg_wdata,
	// input words
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [brf_pkg::W_IN_DATA-1:0]  s_axis_tdata,   // [7:0] data_byte, [18:8] count
	input  logic [brf_pkg::W_KIND-1:0]     s_axis_tuser,   // [2:0] kind
	// result words
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [brf_pkg::W_OUT_DATA-1:0] m_axis_tdata    // [7:0] read_data, [9:8] status,
	                                                       // [20:10] used_bytes,
	                                                       // [31:21] free_bytes,
	                                                       // [42:32] peak_used,
	                                                       // [74:43] full_events,
	                                                       // [106:75] empty_events,
	                                                       // [138:107] bytes_consumed,
	                                                       // [149:139] contiguous_read,
	                                                       // [160:150] contiguous_write
);

	import brf_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	// working width for index, occupancy and capacity arithmetic
	localparam int unsigned CW = ((AW > W_LEN) ? AW : W_LEN) + 1;
	localparam int unsigned W_RES = $bits(result_t);

	// ---------------------------------------------------------------
	// Architectural state
	// ---------------------------------------------------------------
	logic [W_LEN-1:0]   cap_q;
	logic [AW-1:0]      rd_idx_q;
	logic [AW-1:0]      wr_idx_q;
	logic [W_LEN-1:0]   occ_q;
	logic [W_LEN-1:0]   peak_q;
	logic [W_TALLY-1:0] full_q;
	logic [W_TALLY-1:0] empty_q;
	logic [W_TALLY-1:0] cons_q;

	// execute stage: one word waiting for its store read to land
	logic               v_s1;
	logic [W_KIND-1:0]  kind_s1;
	logic [W_BYTE-1:0]  byte_s1;
	logic [W_LEN-1:0]   cnt_s1;
	logic               fwd_s1;
	logic [W_BYTE-1:0]  fwd_byte_s1;

	// output register
	logic               out_valid_q;
	result_t            res_q;

	// ---------------------------------------------------------------
	// Handshake
	// ---------------------------------------------------------------
	logic in_acc;
	logic adv;

	// execute stage retires when the output register is free or being taken
	assign adv           = v_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !v_s1 || adv;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// ---------------------------------------------------------------
	// Execute: read, modify, write back
	// ---------------------------------------------------------------
	logic [CW-1:0]      cap_ext;
	logic [CW-1:0]      cap_eff;
	logic [CW-1:0]      rd_e;
	logic [CW-1:0]      wr_e;
	logic [CW-1:0]      occ_e;
	logic [CW-1:0]      cnt_e;
	logic [CW-1:0]      rd_inc;
	logic [CW-1:0]      wr_inc;
	logic [CW-1:0]      rd_skip;
	logic [CW-1:0]      wr_skip;

	logic [CW-1:0]      rd_n;
	logic [CW-1:0]      wr_n;
	logic [CW-1:0]      occ_n;
	logic [CW-1:0]      peak_n;
	logic [W_TALLY-1:0] full_n;
	logic [W_TALLY-1:0] empty_n;
	logic [W_TALLY-1:0] cons_n;
	status_t            status_n;
	logic [W_BYTE-1:0]  rdata_n;
	logic               mem_we;

	logic [CW-1:0]      free_n;
	logic [CW-1:0]      cread_n;
	logic [CW-1:0]      cwrite_n;

	logic [W_BYTE-1:0]  ram_rdata;
	logic [AW-1:0]      ram_raddr;
	logic [AW-1:0]      ram_waddr;

	// clamp capacity into 1..DEPTH
	assign cap_ext = CW'(cap_q);
	assign cap_eff = (cap_q == '0) ? CW'(1) :
		((cap_ext > CW'(DEPTH)) ? CW'(DEPTH) : cap_ext);

	assign rd_e   = CW'(rd_idx_q);
	assign wr_e   = CW'(wr_idx_q);
	assign occ_e  = CW'(occ_q);
	assign cnt_e  = CW'(cnt_s1);
	assign rd_inc = rd_e + CW'(1);
	assign wr_inc = wr_e + CW'(1);
	// a skip never moves more than one lap, so one subtract wraps it
	assign rd_skip = ((rd_e + cnt_e) >= cap_eff) ? (rd_e + cnt_e - cap_eff) : (rd_e + cnt_e);
	assign wr_skip = ((wr_e + cnt_e) >= cap_eff) ? (wr_e + cnt_e - cap_eff) : (wr_e + cnt_e);

	always_comb begin
		rd_n     = rd_e;
		wr_n     = wr_e;
		occ_n    = occ_e;
		peak_n   = CW'(peak_q);
		full_n   = full_q;
		empty_n  = empty_q;
		cons_n   = cons_q;
		status_n = ST_OK;
		rdata_n  = '0;
		mem_we   = 1'b0;
		unique case (kind_s1)
			KIND_PUSH: begin
				if (occ_e >= cap_eff) begin
					full_n   = full_q + W_TALLY'(1);
					status_n = ST_REFUSED;
				end else begin
					mem_we = 1'b1;
					wr_n   = (wr_inc >= cap_eff) ? '0 : wr_inc;
					occ_n  = occ_e + CW'(1);
				end
			end
			KIND_POP: begin
				if (occ_e == '0) begin
					empty_n  = empty_q + W_TALLY'(1);
					status_n = ST_REFUSED;
				end else begin
					rdata_n = fwd_s1 ? fwd_byte_s1 : ram_rdata;
					rd_n    = (rd_inc >= cap_eff) ? '0 : rd_inc;
					occ_n   = occ_e - CW'(1);
					cons_n  = cons_q + W_TALLY'(1);
				end
			end
			KIND_SKIP_READ: begin
				if (cnt_e > occ_e) begin
					status_n = ST_SKIP;
				end else begin
					rd_n   = rd_skip;
					occ_n  = occ_e - cnt_e;
					cons_n = cons_q + W_TALLY'(cnt_s1);
				end
			end
			KIND_SKIP_WRITE: begin
				if (cnt_e > (cap_eff - occ_e)) begin
					status_n = ST_SKIP;
				end else begin
					wr_n  = wr_skip;
					occ_n = occ_e + cnt_e;
				end
			end
			KIND_CLEAR: begin
				rd_n    = '0;
				wr_n    = '0;
				occ_n   = '0;
				peak_n  = '0;
				full_n  = '0;
				empty_n = '0;
				cons_n  = '0;
			end
			default: begin
				// unknown operation: report state, change nothing
			end
		endcase
		// occupancy only rises on push and skip write; peak never trails it
		if (occ_n > peak_n) begin
			peak_n = occ_n;
		end
	end

	// derived lengths, from the state after the operation
	assign free_n   = cap_eff - occ_n;
	assign cread_n  = (occ_n == '0) ? '0 :
		((rd_n >= wr_n) ? (cap_eff - rd_n) : (wr_n - rd_n));
	assign cwrite_n = (free_n == '0) ? '0 :
		((wr_n >= rd_n) ? (cap_eff - wr_n) : (rd_n - wr_n));

	// ---------------------------------------------------------------
	// Byte store
	// ---------------------------------------------------------------
	// read at the accept edge; when the word ahead retires in the same
	// cycle, use its updated read index
	assign ram_raddr = adv ? AW'(rd_n) : rd_idx_q;
	assign ram_waddr = wr_idx_q;

	brf_ram #(
		.WIDTH (W_BYTE),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (adv && mem_we),
		.waddr (ram_waddr),
		.wdata (byte_s1),
		.re    (in_acc),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ---------------------------------------------------------------
	// Registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			rd_idx_q    <= '0;
			wr_idx_q    <= '0;
			occ_q       <= '0;
			peak_q      <= '0;
			full_q      <= '0;
			empty_q     <= '0;
			cons_q      <= '0;
			v_s1        <= 1'b0;
			fwd_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// capacity write empties the ring, statistics stay
			if (cfg_we) begin
				cap_q    <= cfg_wdata;
				rd_idx_q <= '0;
				wr_idx_q <= '0;
				occ_q    <= '0;
			end else if (adv) begin
				rd_idx_q <= AW'(rd_n);
				wr_idx_q <= AW'(wr_n);
				occ_q    <= W_LEN'(occ_n);
				peak_q   <= W_LEN'(peak_n);
				full_q   <= full_n;
				empty_q  <= empty_n;
				cons_q   <= cons_n;
			end

			if (in_acc) begin
				v_s1 <= 1'b1;
				// bypass a push that lands on the slot being read
				fwd_s1 <= adv && mem_we && (ram_waddr == ram_raddr);
			end else if (adv) begin
				v_s1 <= 1'b0;
			end

			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1     <= s_axis_tuser;
			byte_s1     <= s_axis_tdata[W_BYTE-1:0];
			cnt_s1      <= s_axis_tdata[W_BYTE +: W_LEN];
			fwd_byte_s1 <= byte_s1;
		end
		if (adv) begin
			res_q.read_data        <= rdata_n;
			res_q.status           <= status_n;
			res_q.used_bytes       <= W_LEN'(occ_n);
			res_q.free_bytes       <= W_LEN'(free_n);
			res_q.peak_used        <= W_LEN'(peak_n);
			res_q.full_events      <= full_n;
			res_q.empty_events     <= empty_n;
			res_q.bytes_consumed   <= cons_n;
			res_q.contiguous_read  <= W_LEN'(cread_n);
			res_q.contiguous_write <= W_LEN'(cwrite_n);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(W_OUT_DATA - W_RES)'(0), res_q};

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for byte_ring_fifo_with_stats: random and directed words on
// s_axis, per-field checks of every result word on m_axis against an in-bench FIFO model.
// Depends on brf_pkg (widths, kind and status codes, result layout) and the RTL only.
module tb;
	import brf_pkg::*;

	localparam int unsigned DEPTH = DEPTH_DEF;
	// Two copies of the FIFO model: one follows accepted words, one runs ahead while
	// stimulus is queued so that generation knows occupancy and written slots.
	localparam int MODEL_CHK  = 0;
	localparam int MODEL_PLAN = 1;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int RANDOM_CHUNKS = 17;
	localparam int CHUNK_WORDS = 48;
	// Kinds the block does not decode; they must leave the state alone
	localparam logic [W_KIND-1:0] KIND_UNUSED_LO = 3'd5;
	localparam logic [W_KIND-1:0] KIND_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [W_KIND-1:0] kind;
		logic [W_BYTE-1:0] data_byte;
		logic [W_LEN-1:0]  count;
	} fifo_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [W_LEN-1:0]      cfg_wdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [W_IN_DATA-1:0]  s_axis_tdata = '0;   // [7:0] data_byte, [18:8] count
	logic [W_KIND-1:0]     s_axis_tuser = '0;   // [2:0] kind
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [W_OUT_DATA-1:0] m_axis_tdata;        // read_data, status, used_bytes, free_bytes,
	                                            // peak_used, full_events, empty_events,
	                                            // bytes_consumed, contiguous_read,
	                                            // contiguous_write

	byte_ring_fifo_with_stats #(
		.DEPTH(DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	// FIFO model state, one row per model copy
	logic [W_LEN-1:0]   cap_reg      [2];
	logic [W_BYTE-1:0]  mem_img      [2][DEPTH];
	bit                 mem_set      [2][DEPTH];
	logic [9:0]         rd_ptr       [2];
	logic [9:0]         wr_ptr       [2];
	logic [W_LEN-1:0]   fill         [2];
	logic [W_LEN-1:0]   peak         [2];
	logic [W_TALLY-1:0] full_cnt     [2];
	logic [W_TALLY-1:0] empty_cnt    [2];
	logic [W_TALLY-1:0] consumed_cnt [2];

	fifo_word_t word_queue[$];        // words waiting for the driver
	result_t    expected_results[$];  // one per accepted word, oldest first

	int unsigned words_queued = 0;
	int unsigned words_accepted = 0;
	int unsigned results_checked = 0;
	int unsigned cap_writes = 0;
	int unsigned errors = 0;
	int unsigned cycle_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned sink_idle_pct = 0;
	int unsigned send_hold = 0;
	int unsigned sink_hold = 0;
	bit          word_taken = 1'b0;

	// Capacity as the block uses it: 0 acts as 1, anything above DEPTH as DEPTH
	function automatic int unsigned eff_capacity(input int m);
		if (cap_reg[m] == '0)
			return 1;
		if (cap_reg[m] > DEPTH)
			return DEPTH;
		return int'(cap_reg[m]);
	endfunction

	// Apply one word to model copy m and return the result word it produces
	function automatic result_t fifo_step(input int m, input fifo_word_t w);
		result_t r;
		int unsigned cap;
		int unsigned pos;
		cap = eff_capacity(m);
		r = '0;
		r.status = ST_OK;
		case (w.kind)
			KIND_PUSH: begin
				if (fill[m] >= cap) begin
					full_cnt[m] += 1;
					r.status = ST_REFUSED;
				end else begin
					mem_img[m][wr_ptr[m]] = w.data_byte;
					mem_set[m][wr_ptr[m]] = 1'b1;
					pos = wr_ptr[m] + 1;
					wr_ptr[m] = (pos >= cap) ? '0 : 10'(pos);
					fill[m] += 1'b1;
					if (fill[m] > peak[m])
						peak[m] = fill[m];
				end
			end
			KIND_POP: begin
				if (fill[m] == '0) begin
					empty_cnt[m] += 1;
					r.status = ST_REFUSED;
				end else begin
					r.read_data = mem_img[m][rd_ptr[m]];
					pos = rd_ptr[m] + 1;
					rd_ptr[m] = (pos >= cap) ? '0 : 10'(pos);
					fill[m] -= 1'b1;
					consumed_cnt[m] += 1;
				end
			end
			KIND_SKIP_READ: begin
				if (w.count > fill[m]) begin
					r.status = ST_SKIP;
				end else begin
					pos = rd_ptr[m] + w.count;
					if (pos >= cap)
						pos -= cap;
					rd_ptr[m] = 10'(pos);
					fill[m] -= w.count;
					consumed_cnt[m] += W_TALLY'(w.count);
				end
			end
			KIND_SKIP_WRITE: begin
				if (w.count > cap - fill[m]) begin
					r.status = ST_SKIP;
				end else begin
					pos = wr_ptr[m] + w.count;
					if (pos >= cap)
						pos -= cap;
					wr_ptr[m] = 10'(pos);
					fill[m] += w.count;
					if (fill[m] > peak[m])
						peak[m] = fill[m];
				end
			end
			KIND_CLEAR: begin
				rd_ptr[m] = '0;
				wr_ptr[m] = '0;
				fill[m] = '0;
				peak[m] = '0;
				full_cnt[m] = '0;
				empty_cnt[m] = '0;
				consumed_cnt[m] = '0;
			end
			default: ;
		endcase

		r.used_bytes = fill[m];
		r.free_bytes = W_LEN'(cap - fill[m]);
		r.peak_used = peak[m];
		r.full_events = full_cnt[m];
		r.empty_events = empty_cnt[m];
		r.bytes_consumed = consumed_cnt[m];
		if (fill[m] == '0)
			r.contiguous_read = '0;
		else if (rd_ptr[m] >= wr_ptr[m])
			r.contiguous_read = W_LEN'(cap - rd_ptr[m]);
		else
			r.contiguous_read = W_LEN'(wr_ptr[m] - rd_ptr[m]);
		if (fill[m] == cap)
			r.contiguous_write = '0;
		else if (wr_ptr[m] >= rd_ptr[m])
			r.contiguous_write = W_LEN'(cap - wr_ptr[m]);
		else
			r.contiguous_write = W_LEN'(rd_ptr[m] - wr_ptr[m]);
		return r;
	endfunction

	// Queue one word for the driver and advance the look-ahead model past it
	function automatic void queue_word(input logic [W_KIND-1:0] k, input logic [W_BYTE-1:0] b,
			input logic [W_LEN-1:0] c);
		fifo_word_t w;
		w.kind = k;
		w.data_byte = b;
		w.count = c;
		// A write skip reserves slots that no push has filled; never pop one of those.
		// Skip over the slot instead so the read side still moves.
		if (k == KIND_POP && fill[MODEL_PLAN] != '0 && !mem_set[MODEL_PLAN][rd_ptr[MODEL_PLAN]]) begin
			w.kind = KIND_SKIP_READ;
			w.count = W_LEN'(1);
		end
		void'(fifo_step(MODEL_PLAN, w));
		word_queue.push_back(w);
		words_queued++;
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 40)
			$display("MISMATCH cycle %0d: %s", cycle_count, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
				results_checked, name, got, want));
	endtask

	// Block until every queued word is accepted and every result word has come back
	task automatic wait_drained();
		while (words_accepted != words_queued || expected_results.size() != 0)
			@(negedge clk);
	endtask

	// Write the capacity register with the FIFO idle; both model copies empty with it
	task automatic write_capacity(input logic [W_LEN-1:0] value);
		wait_drained();
		repeat (2) @(negedge clk);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		for (int m = 0; m < 2; m++) begin
			cap_reg[m] = value;
			rd_ptr[m] = '0;
			wr_ptr[m] = '0;
			fill[m] = '0;
		end
		cap_writes++;
	endtask

	initial begin
		forever #10 clk = ~clk;
	end

	// Hard stop on a hung handshake
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_results.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Driver: present the next queued word at the falling edge once the current one is
	// taken, with random idle bursts between words.
	always @(negedge clk) begin : word_driver
		fifo_word_t w;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || word_taken) begin
			if (send_hold > 0) begin
				send_hold--;
				s_axis_tvalid <= 1'b0;
			end else if (word_queue.size() == 0) begin
				s_axis_tvalid <= 1'b0;
			end else if ($urandom_range(0, 99) < send_idle_pct) begin
				send_hold = $urandom_range(0, 5);
				s_axis_tvalid <= 1'b0;
			end else begin
				w = word_queue.pop_front();
				s_axis_tuser <= w.kind;
				s_axis_tdata <= W_IN_DATA'({w.count, w.data_byte});
				s_axis_tvalid <= 1'b1;
			end
		end
	end

	// Result side back-pressure: drop tready in random bursts
	always @(negedge clk) begin : result_sink
		if (sink_hold > 0) begin
			sink_hold--;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 99) < sink_idle_pct) begin
			sink_hold = $urandom_range(0, 5);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Monitor: compare each result word with the oldest expectation, then predict the
	// result of any word accepted at this edge.
	always @(posedge clk) begin : result_monitor
		fifo_word_t w;
		result_t got;
		result_t want;
		if (!arst_n) begin
			word_taken = 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_checked++;
				got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with nothing expected",
						results_checked));
				end else begin
					want = expected_results.pop_front();
					check_field("read_data", 32'(got.read_data), 32'(want.read_data));
					check_field("status", 32'(got.status), 32'(want.status));
					check_field("used_bytes", 32'(got.used_bytes), 32'(want.used_bytes));
					check_field("free_bytes", 32'(got.free_bytes), 32'(want.free_bytes));
					check_field("peak_used", 32'(got.peak_used), 32'(want.peak_used));
					check_field("full_events", got.full_events, want.full_events);
					check_field("empty_events", got.empty_events, want.empty_events);
					check_field("bytes_consumed", got.bytes_consumed, want.bytes_consumed);
					check_field("contiguous_read", 32'(got.contiguous_read),
						32'(want.contiguous_read));
					check_field("contiguous_write", 32'(got.contiguous_write),
						32'(want.contiguous_write));
					// padding above the last field must stay zero
					check_field("tdata padding",
						32'(m_axis_tdata[W_OUT_DATA-1:$bits(result_t)]), 32'd0);
				end
			end
			word_taken = s_axis_tvalid && s_axis_tready;
			if (word_taken) begin
				w.kind = s_axis_tuser;
				w.data_byte = s_axis_tdata[W_BYTE-1:0];
				w.count = s_axis_tdata[W_BYTE+W_LEN-1:W_BYTE];
				expected_results.push_back(fifo_step(MODEL_CHK, w));
				words_accepted++;
			end
		end
	end

	initial begin : stimulus
		int unsigned cap;
		int unsigned room;
		int unsigned r;
		logic [W_LEN-1:0] c;

		for (int m = 0; m < 2; m++) begin
			cap_reg[m] = CAP_RESET;
			rd_ptr[m] = '0;
			wr_ptr[m] = '0;
			fill[m] = '0;
			peak[m] = '0;
			full_cnt[m] = '0;
			empty_cnt[m] = '0;
			consumed_cnt[m] = '0;
		end

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words at the reset capacity
		send_idle_pct = 20;
		sink_idle_pct = 20;
		queue_word(KIND_POP, 8'($urandom), 11'($urandom));           // empty refusal
		queue_word(KIND_SKIP_READ, 8'($urandom), W_LEN'(0));         // zero count skip
		queue_word(KIND_SKIP_READ, 8'($urandom), W_LEN'(1));         // more than stored
		queue_word(KIND_SKIP_READ, 8'($urandom), W_LEN'(2047));
		queue_word(KIND_PUSH, 8'h00, 11'($urandom));
		queue_word(KIND_PUSH, 8'hFF, 11'($urandom));
		queue_word(KIND_PUSH, 8'hA5, 11'($urandom));
		queue_word(KIND_POP, 8'($urandom), 11'($urandom));
		queue_word(KIND_POP, 8'($urandom), 11'($urandom));
		for (int k = KIND_UNUSED_LO; k <= KIND_UNUSED_HI; k++)
			queue_word(W_KIND'(k), 8'($urandom), 11'($urandom));
		queue_word(KIND_SKIP_WRITE, 8'($urandom), W_LEN'(1023));     // fill to full, wraps
		queue_word(KIND_PUSH, 8'h5A, 11'($urandom));                 // full refusal
		queue_word(KIND_SKIP_WRITE, 8'($urandom), W_LEN'(1));        // more than free
		queue_word(KIND_SKIP_READ, 8'($urandom), W_LEN'(1024));      // drain everything
		queue_word(KIND_SKIP_WRITE, 8'($urandom), W_LEN'(1024));
		queue_word(KIND_SKIP_WRITE, 8'($urandom), W_LEN'(2047));
		queue_word(KIND_SKIP_READ, 8'($urandom), W_LEN'(2047));
		queue_word(KIND_CLEAR, 8'($urandom), 11'($urandom));
		queue_word(KIND_POP, 8'($urandom), 11'($urandom));

		// Capacity 0 behaves as a single slot
		write_capacity(W_LEN'(0));
		queue_word(KIND_PUSH, 8'h3C, 11'($urandom));
		queue_word(KIND_PUSH, 8'hC3, 11'($urandom));
		queue_word(KIND_POP, 8'($urandom), 11'($urandom));
		queue_word(KIND_POP, 8'($urandom), 11'($urandom));
		queue_word(KIND_SKIP_WRITE, 8'($urandom), W_LEN'(1));
		queue_word(KIND_SKIP_READ, 8'($urandom), W_LEN'(1));
		queue_word(KIND_SKIP_WRITE, 8'($urandom), W_LEN'(2));

		// Random chunks; change capacity every other chunk with the FIFO drained
		for (int k = 0; k < RANDOM_CHUNKS; k++) begin
			if (k % 2 == 0) begin
				case (k)
					0: c = W_LEN'(2047);
					2: c = W_LEN'(1);
					4: c = W_LEN'(2);
					6: c = W_LEN'(1024);
					8: c = W_LEN'(1023);
					default: c = ($urandom_range(0, 3) == 0) ? W_LEN'($urandom_range(13, 1022))
						: W_LEN'($urandom_range(2, 12));
				endcase
				write_capacity(c);
			end
			// no idling at all in the closing chunks, mixed levels before that
			if (k >= RANDOM_CHUNKS - 3) begin
				send_idle_pct = 0;
				sink_idle_pct = 0;
			end else begin
				send_idle_pct = $urandom_range(0, 2) * 15;
				sink_idle_pct = $urandom_range(0, 2) * 15;
			end
			for (int i = 0; i < CHUNK_WORDS; i++) begin
				cap = eff_capacity(MODEL_PLAN);
				room = cap - fill[MODEL_PLAN];
				r = $urandom_range(0, 99);
				if (r < 34) begin
					queue_word(KIND_PUSH, 8'($urandom), 11'($urandom));
				end else if (r < 64) begin
					queue_word(KIND_POP, 8'($urandom), 11'($urandom));
				end else if (r < 76) begin
					if ($urandom_range(0, 4) == 0)
						c = W_LEN'($urandom_range(int'(fill[MODEL_PLAN]) + 1, 2047));
					else
						c = W_LEN'($urandom_range(0, int'(fill[MODEL_PLAN])));
					queue_word(KIND_SKIP_READ, 8'($urandom), c);
				end else if (r < 88) begin
					if ($urandom_range(0, 4) == 0)
						c = W_LEN'($urandom_range(room + 1, 2047));
					else
						c = W_LEN'($urandom_range(0, room));
					queue_word(KIND_SKIP_WRITE, 8'($urandom), c);
				end else if (r < 92) begin
					queue_word(KIND_CLEAR, 8'($urandom), 11'($urandom));
				end else if (r < 96) begin
					queue_word(W_KIND'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI)),
						8'($urandom), 11'($urandom));
				end else begin
					queue_word(KIND_PUSH, 8'($urandom), 11'($urandom));
				end
			end
			// hold the next chunk's idle levels until this chunk is on the bus
			while (words_accepted != words_queued)
				@(negedge clk);
		end

		wait_drained();
		repeat (8) @(negedge clk);

		$display("run summary: %0d words in, %0d result words compared, %0d capacity writes",
			words_accepted, results_checked, cap_writes);
		$display("run summary: %s", {"full and empty refusals, fitting and oversized skips,",
			" clears, undecoded kinds, capacities 0, 1, 2, 1023, 1024 and 2047 among others"});
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
